// ----- hdl/hse_pkg.sv -----
package hse_pkg;
    localparam int BlockBytes = 64;
    localparam int KeyWords = 8;
    localparam int DigestWords = 5;
    localparam logic [7:0] Ipad = 8'h36;
    localparam logic [7:0] Opad = 8'h5C;

    localparam logic [159:0] ShaIv = {32'h67452301, 32'hEFCDAB89, 32'h98BADCFE,
                                      32'h10325476, 32'hC3D2E1F0};

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_LOAD  = 8'b0000_0010,
        S_ROUND = 8'b0000_0100,
        S_ADD   = 8'b0000_1000,
        S_PAD   = 8'b0001_0000,
        S_OUTER = 8'b0010_0000,
        S_EMIT  = 8'b0100_0000,
        S_RDY   = 8'b1000_0000
    } t_state;

    // what the compression unit hashes next
    typedef enum logic [5:0] {
        J_IKEY  = 6'b000001,
        J_MSG   = 6'b000010,
        J_PAD1  = 6'b000100,
        J_PAD2  = 6'b001000,
        J_OKEY  = 6'b010000,
        J_OMSG  = 6'b100000
    } t_job;

    function automatic logic [31:0] rotl(input logic [31:0] x, input int n);
        rotl = (x << n) | (x >> (32 - n));
    endfunction
endpackage

// ----- hdl/hmac_sha1_engine_core.sv -----
// A request with no byte returns to ready through the idle state; one with a byte
// first writes the byte, and a byte that fills the block also hashes it (load, 80 shared rounds, add).
// The first request of a message first hashes the inner key block.
// A last request adds a pad step, 1 or 2 inner blocks and 2 outer blocks, then five
// results, one per cycle while the receiver is ready.
// Reset (synchronous, active low) clears keys and control state and loads the chain value with the SHA-1 IV.
module hmac_sha1_engine_core (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_present,
    input  logic        i_is_last,
    input  logic        i_cfg_we,
    input  logic [2:0]  i_cfg_index,
    input  logic [63:0] i_cfg_data,
    output logic        o_valid,
    input  logic        i_ready,
    output logic [31:0] o_mac_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);
    import hse_pkg::*;

    logic [63:0]  r_key [KeyWords];
    logic [511:0] r_blk;          // message block buffer, byte 0 in top bits
    logic [6:0]   r_fill, n_fill;
    logic [63:0]  r_len;
    logic         r_kdone;
    logic [159:0] r_h, r_oh, r_inner;
    logic [511:0] r_w;            // 16-word schedule window
    logic [31:0]  r_a, r_b, r_c, r_d, r_e;
    logic [6:0]   r_rnd;
    t_state       r_st;
    t_job         r_job;
    logic         r_last, r_pres;
    logic [7:0]   r_byte;
    logic [2:0]   r_oidx;

    logic [511:0] key_ipad, key_opad, pad_blk, omsg_blk, load_blk;
    logic [159:0] load_h;
    logic [31:0]  f, k, t, w0, wn;
    logic [63:0]  bits;

    always_comb begin
        for (int i = 0; i < KeyWords; i++) begin
            for (int j = 0; j < 8; j++) begin
                key_ipad[511 - 64*i - 8*j -: 8] = r_key[i][63 - 8*j -: 8] ^ Ipad;
                key_opad[511 - 64*i - 8*j -: 8] = r_key[i][63 - 8*j -: 8] ^ Opad;
            end
        end
    end

    assign bits = r_len << 3;
    // zero past the 0x80 marker; on J_PAD2 r_fill already counts the marker
    always_comb begin
        pad_blk = r_blk;
        for (int i = 0; i < BlockBytes; i++) begin
            if ((r_job == J_PAD1) ? (7'(i) > r_fill) : (7'(i) >= r_fill))
                pad_blk[511 - 8*i -: 8] = 8'h00;
        end
        if (r_job == J_PAD2) pad_blk[63:0] = bits;
    end

    assign omsg_blk = {r_inner, 8'h80, 280'd0, 64'd672};

    always_comb begin
        load_blk = r_blk;
        load_h   = r_h;
        case (r_job)
            J_IKEY:  begin load_blk = key_ipad; load_h = r_h;  end
            J_MSG:   begin load_blk = r_blk;    load_h = r_h;  end
            J_PAD1:  begin load_blk = pad_blk;  load_h = r_h;  end
            J_PAD2:  begin load_blk = pad_blk;  load_h = r_h;  end
            J_OKEY:  begin load_blk = key_opad; load_h = ShaIv; end
            J_OMSG:  begin load_blk = omsg_blk; load_h = r_oh; end
            default: begin load_blk = r_blk;    load_h = r_h;  end
        endcase
    end

    // shared round unit
    always_comb begin
        if (r_rnd < 7'd20) begin
            f = (r_b & r_c) | (~r_b & r_d); k = 32'h5A827999;
        end else if (r_rnd < 7'd40) begin
            f = r_b ^ r_c ^ r_d; k = 32'h6ED9EBA1;
        end else if (r_rnd < 7'd60) begin
            f = (r_b & r_c) | (r_b & r_d) | (r_c & r_d); k = 32'h8F1BBCDC;
        end else begin
            f = r_b ^ r_c ^ r_d; k = 32'hCA62C1D6;
        end
        w0 = r_w[511 -: 32];
        t  = rotl(r_a, 5) + f + r_e + k + w0;
        wn = rotl(r_w[511-13*32 -: 32] ^ r_w[511-8*32 -: 32] ^ r_w[511-2*32 -: 32] ^ w0, 1);
    end

    assign n_fill = r_fill + 7'd1;
    assign o_ready = (r_st == S_RDY);
    assign o_valid = (r_st == S_EMIT);
    assign o_mac_word = r_oh[159 - 32*r_oidx -: 32];
    assign o_word_index = r_oidx;
    assign o_last_word = (r_oidx == 3'(DigestWords - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int i = 0; i < KeyWords; i++) r_key[i] <= '0;
        end else if (i_cfg_we) begin
            r_key[i_cfg_index] <= i_cfg_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_RDY; r_h <= ShaIv; r_fill <= '0; r_len <= '0;
            r_kdone <= 1'b0; r_oidx <= '0; r_job <= J_IKEY; r_rnd <= '0;
        end else begin
            case (r_st)
                S_RDY: if (i_valid) begin
                    r_last <= i_is_last; r_pres <= i_byte_present; r_byte <= i_data_byte;
                    if (!r_kdone) begin
                        r_job <= J_IKEY; r_st <= S_LOAD;
                    end else r_st <= S_IDLE;
                end
                S_IDLE: begin
                    // take in the byte
                    if (r_pres) begin
                        r_blk[511 - 8*r_fill[5:0] -: 8] <= r_byte;
                        r_len <= r_len + 64'd1;
                        r_pres <= 1'b0;
                        if (n_fill == 7'(BlockBytes)) begin
                            r_fill <= '0; r_job <= J_MSG; r_st <= S_LOAD;
                        end else r_fill <= n_fill;
                    end else if (r_last) begin
                        r_st <= S_PAD;
                    end else r_st <= S_RDY;
                end
                S_PAD: begin
                    r_blk[511 - 8*r_fill[5:0] -: 8] <= 8'h80;
                    if (r_fill >= 7'd56) begin
                        r_job <= J_PAD1;
                    end else begin
                        r_job <= J_PAD2; r_fill <= n_fill;
                    end
                    r_st <= S_LOAD;
                end
                S_LOAD: begin
                    r_w <= load_blk;
                    {r_a, r_b, r_c, r_d, r_e} <= load_h;
                    if (r_job == J_OKEY) r_oh <= ShaIv;
                    r_rnd <= '0; r_st <= S_ROUND;
                end
                S_ROUND: begin
                    r_a <= t; r_b <= r_a; r_c <= rotl(r_b, 30); r_d <= r_c; r_e <= r_d;
                    r_w <= {r_w[479:0], wn};
                    r_rnd <= r_rnd + 7'd1;
                    if (r_rnd == 7'd79) r_st <= S_ADD;
                end
                S_ADD: begin
                    case (r_job)
                        J_IKEY: begin
                            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                                    r_h[63:32] + r_d, r_h[31:0] + r_e};
                            r_kdone <= 1'b1; r_len <= 64'(BlockBytes); r_st <= S_IDLE;
                        end
                        J_MSG: begin
                            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                                    r_h[63:32] + r_d, r_h[31:0] + r_e};
                            r_st <= S_IDLE;
                        end
                        J_PAD1: begin
                            // 0x80 sat past byte 55: finish with an all-zero length block
                            r_h <= {r_h[159:128] + r_a, r_h[127:96] + r_b, r_h[95:64] + r_c,
                                    r_h[63:32] + r_d, r_h[31:0] + r_e};
                            r_fill <= '0; r_job <= J_PAD2; r_st <= S_LOAD;
                        end
                        J_PAD2: begin
                            r_inner <= {r_h[159:128] + r_a, r_h[127:96] + r_b,
                                        r_h[95:64] + r_c, r_h[63:32] + r_d, r_h[31:0] + r_e};
                            r_job <= J_OKEY; r_st <= S_LOAD;
                        end
                        J_OKEY: begin
                            r_oh <= {r_oh[159:128] + r_a, r_oh[127:96] + r_b,
                                     r_oh[95:64] + r_c, r_oh[63:32] + r_d, r_oh[31:0] + r_e};
                            r_job <= J_OMSG; r_st <= S_LOAD;
                        end
                        default: begin
                            r_oh <= {r_oh[159:128] + r_a, r_oh[127:96] + r_b,
                                     r_oh[95:64] + r_c, r_oh[63:32] + r_d, r_oh[31:0] + r_e};
                            r_oidx <= '0; r_st <= S_EMIT;
                        end
                    endcase
                end
                S_EMIT: if (i_ready) begin
                    if (r_oidx == 3'(DigestWords - 1)) begin
                        r_oidx <= '0; r_h <= ShaIv; r_fill <= '0; r_len <= '0;
                        r_kdone <= 1'b0; r_st <= S_RDY;
                    end else r_oidx <= r_oidx + 3'd1;
                end
                default: r_st <= S_RDY;
            endcase
        end
    end
endmodule

// ----- tb/sv/hmac_sha1_engine_core_tb.sv -----
`timescale 1ns / 1ps

module hmac_sha1_engine_core_tb;
    import hse_pkg::*;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       byte_present;
        logic       is_last;
    } t_req;

    typedef struct packed {
        logic [31:0] mac_word;
        logic [2:0]  word_index;
        logic        last_word;
    } t_mac;

    // a directed row: request plus, where known, the first MAC word of the message
    typedef struct packed {
        t_req        req;
        logic        has_word0;
        logic [31:0] word0;
    } t_row;

    localparam int WatchdogLimit = 20000;
    localparam int DrainCycles = 600;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_valid;
    logic        o_ready;
    logic [7:0]  i_data_byte;
    logic        i_byte_present;
    logic        i_is_last;
    logic        i_cfg_we;
    logic [2:0]  i_cfg_index;
    logic [63:0] i_cfg_data;
    logic        o_valid;
    logic        i_ready;
    logic [31:0] o_mac_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    hmac_sha1_engine_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(i_valid), .o_ready(o_ready),
        .i_data_byte(i_data_byte), .i_byte_present(i_byte_present),
        .i_is_last(i_is_last),
        .i_cfg_we(i_cfg_we), .i_cfg_index(i_cfg_index), .i_cfg_data(i_cfg_data),
        .o_valid(o_valid), .i_ready(i_ready),
        .o_mac_word(o_mac_word), .o_word_index(o_word_index),
        .o_last_word(o_last_word)
    );

    // predictor state
    logic [63:0] key_reg [KeyWords];
    logic [31:0] run_hash [DigestWords];
    logic [7:0]  blk_buf [BlockBytes];
    int          blk_fill;
    logic [63:0] msg_len;
    logic        ikey_done;

    t_mac        mac_queue[$];
    int          errors;
    int          idle_cycles;
    logic        rx_hold;
    logic        rx_no_idle;
    logic        tx_no_idle;
    logic        tx_done;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic logic [31:0] rol(input logic [31:0] x, input int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    task automatic sha1_compress(inout logic [31:0] h [DigestWords],
                                 input logic [7:0] b [BlockBytes]);
        logic [31:0] w [80];
        logic [31:0] a, bb, c, d, e, f, k, t;
        for (int i = 0; i < 16; i++)
            w[i] = {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]};
        for (int i = 16; i < 80; i++)
            w[i] = rol(w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16], 1);
        a = h[0]; bb = h[1]; c = h[2]; d = h[3]; e = h[4];
        for (int i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (bb & c) | (~bb & d); k = 32'h5A827999;
            end else if (i < 40) begin
                f = bb ^ c ^ d; k = 32'h6ED9EBA1;
            end else if (i < 60) begin
                f = (bb & c) | (bb & d) | (c & d); k = 32'h8F1BBCDC;
            end else begin
                f = bb ^ c ^ d; k = 32'hCA62C1D6;
            end
            t = rol(a, 5) + f + e + k + w[i];
            e = d; d = c; c = rol(bb, 30); bb = a; a = t;
        end
        h[0] += a; h[1] += bb; h[2] += c; h[3] += d; h[4] += e;
    endtask

    task automatic padded_key(output logic [7:0] b [BlockBytes], input logic [7:0] pad);
        for (int i = 0; i < BlockBytes; i++)
            b[i] = key_reg[i / 8][63 - 8 * (i % 8) -: 8] ^ pad;
    endtask

    task automatic put_bit_length(inout logic [7:0] b [BlockBytes], input logic [63:0] n);
        logic [63:0] bits;
        bits = n << 3;
        for (int i = 0; i < 8; i++)
            b[56 + i] = bits[63 - 8 * i -: 8];
    endtask

    task automatic start_msg();
        for (int i = 0; i < DigestWords; i++)
            run_hash[i] = ShaIv[159 - 32 * i -: 32];
        blk_fill = 0;
        msg_len = '0;
        ikey_done = 1'b0;
    endtask

    task automatic hmac_absorb(input t_req r);
        logic [7:0]  b [BlockBytes];
        logic [31:0] outer [DigestWords];
        t_mac        m;
        if (!ikey_done) begin
            padded_key(b, Ipad);
            sha1_compress(run_hash, b);
            msg_len = 64'(BlockBytes);
            ikey_done = 1'b1;
        end
        if (r.byte_present) begin
            blk_buf[blk_fill] = r.data_byte;
            blk_fill++;
            msg_len++;
            if (blk_fill >= BlockBytes) begin
                sha1_compress(run_hash, blk_buf);
                blk_fill = 0;
            end
        end
        if (!r.is_last)
            return;
        blk_buf[blk_fill] = 8'h80;
        blk_fill++;
        if (blk_fill > 56) begin
            for (int i = blk_fill; i < BlockBytes; i++)
                blk_buf[i] = 8'h00;
            sha1_compress(run_hash, blk_buf);
            blk_fill = 0;
        end
        for (int i = blk_fill; i < 56; i++)
            blk_buf[i] = 8'h00;
        put_bit_length(blk_buf, msg_len);
        sha1_compress(run_hash, blk_buf);
        for (int i = 0; i < DigestWords; i++)
            outer[i] = ShaIv[159 - 32 * i -: 32];
        padded_key(b, Opad);
        sha1_compress(outer, b);
        for (int i = 0; i < BlockBytes; i++)
            b[i] = 8'h00;
        for (int i = 0; i < DigestWords; i++)
            {b[4*i], b[4*i+1], b[4*i+2], b[4*i+3]} = run_hash[i];
        b[20] = 8'h80;
        put_bit_length(b, 64'(BlockBytes + 4 * DigestWords));
        sha1_compress(outer, b);
        for (int i = 0; i < DigestWords; i++) begin
            m.mac_word = outer[i];
            m.word_index = 3'(i);
            m.last_word = (i == DigestWords - 1);
            mac_queue = {mac_queue, m};
        end
        start_msg();
    endtask

    // raise the write enable; cfg_off drops it once the writes are done
    task automatic write_key(input int idx, input logic [63:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= 3'(idx);
        i_cfg_data <= val;
        key_reg[idx] = val;
        @(negedge i_clk);
    endtask

    task automatic cfg_off();
        i_cfg_we <= 1'b0;
    endtask

    // wait for the MAC queue to drain, then let the block settle
    task automatic wait_drained();
        i_valid <= 1'b0;
        while (mac_queue.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
    endtask

    task automatic send_req(input t_req r);
        while (!tx_no_idle && $urandom_range(99) < 16) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid <= 1'b1;
        i_data_byte <= r.data_byte;
        i_byte_present <= r.byte_present;
        i_is_last <= r.is_last;
        @(posedge i_clk);
        while (!o_ready)
            @(posedge i_clk);
        hmac_absorb(r);
        @(negedge i_clk);
    endtask

    function automatic t_req mk_req(input logic [7:0] d, input logic p, input logic l);
        t_req r;
        r.data_byte = d;
        r.byte_present = p;
        r.is_last = l;
        return r;
    endfunction

    // results side
    always @(posedge i_clk) begin
        t_mac want;
        if (i_rst_n && o_valid && i_ready) begin
            idle_cycles <= 0;
            if (mac_queue.size() == 0) begin
                $error("unexpected MAC word %h", o_mac_word);
                errors++;
            end else begin
                want = mac_queue.pop_front();
                if (o_mac_word !== want.mac_word) begin
                    $error("mac_word expected %h actual %h", want.mac_word, o_mac_word);
                    errors++;
                end
                if (o_word_index !== want.word_index) begin
                    $error("word_index expected %0d actual %0d", want.word_index,
                           o_word_index);
                    errors++;
                end
                if (o_last_word !== want.last_word) begin
                    $error("last_word expected %0d actual %0d", want.last_word,
                           o_last_word);
                    errors++;
                end
            end
        end else if (i_rst_n && i_valid && o_ready) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
        end
    end

    always @(negedge i_clk) begin
        if (rx_hold)
            i_ready <= 1'b0;
        else if (rx_no_idle)
            i_ready <= 1'b1;
        else
            i_ready <= ($urandom_range(99) >= 16);
    end

    always @(posedge i_clk) begin
        if (idle_cycles >= WatchdogLimit) begin
            $display("[hmac_sha1_engine_core] ERROR");
            $finish;
        end
    end

    // long receiver hold while the sender keeps offering messages
    initial begin
        rx_hold = 1'b0;
        wait (tx_done === 1'b0 && i_rst_n === 1'b1);
        repeat (3000) @(negedge i_clk);
        rx_hold = 1'b1;
        repeat (1500) @(negedge i_clk);
        rx_hold = 1'b0;
    end

    t_row dir_rows [$];

    initial begin
        t_row row;
        t_req r;
        int   n;
        int   gap_word;
        errors = 0;
        idle_cycles = 0;
        rx_no_idle = 1'b0;
        tx_no_idle = 1'b0;
        tx_done = 1'b1;
        i_rst_n = 1'b0;
        i_valid = 1'b0;
        i_data_byte = '0;
        i_byte_present = 1'b0;
        i_is_last = 1'b0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        for (int i = 0; i < KeyWords; i++)
            key_reg[i] = '0;
        start_msg();
        repeat (9) @(negedge i_clk);
        i_rst_n <= 1'b1;
        tx_done = 1'b0;
        @(negedge i_clk);

        // empty message under the all-zero reset key: HMAC-SHA1("", "")
        row = '{req: mk_req(8'h00, 1'b0, 1'b1), has_word0: 1'b1, word0: 32'hfbdb1d1b};
        dir_rows = {dir_rows, row};
        row = '{req: mk_req(8'h00, 1'b0, 1'b0), has_word0: 1'b0, word0: '0};
        dir_rows = {dir_rows, row};
        row = '{req: mk_req(8'hFF, 1'b1, 1'b0), has_word0: 1'b0, word0: '0};
        dir_rows = {dir_rows, row};
        row = '{req: mk_req(8'h00, 1'b1, 1'b0), has_word0: 1'b0, word0: '0};
        dir_rows = {dir_rows, row};
        row = '{req: mk_req(8'hA5, 1'b0, 1'b0), has_word0: 1'b0, word0: '0};
        dir_rows = {dir_rows, row};
        row = '{req: mk_req(8'h5A, 1'b1, 1'b1), has_word0: 1'b0, word0: '0};
        dir_rows = {dir_rows, row};
        row = '{req: mk_req(8'hFF, 1'b0, 1'b1), has_word0: 1'b0, word0: '0};
        dir_rows = {dir_rows, row};
        foreach (dir_rows[j]) begin
            send_req(dir_rows[j].req);
            if (dir_rows[j].has_word0) begin
                if (mac_queue[0].mac_word !== dir_rows[j].word0) begin
                    $error("mac_word expected %h actual %h", dir_rows[j].word0,
                           mac_queue[0].mac_word);
                    errors++;
                end
            end
        end
        wait_drained();

        // extreme keys: all ones, then a 64-byte message crossing the block edge and a 56-byte one
        for (int i = 0; i < KeyWords; i++)
            write_key(i, {64{1'b1}});
        cfg_off();
        for (int i = 0; i < 64; i++)
            send_req(mk_req(8'(i * 37), 1'b1, (i == 63)));
        for (int i = 0; i < 56; i++)
            send_req(mk_req(8'(~i), 1'b1, (i == 55)));
        wait_drained();

        // key change between the inner key block and the outer hash
        write_key(0, 64'h0123_4567_89AB_CDEF);
        cfg_off();
        send_req(mk_req(8'h11, 1'b1, 1'b0));
        wait_drained();
        write_key(0, 64'hFEDC_BA98_7654_3210);
        cfg_off();
        send_req(mk_req(8'h22, 1'b1, 1'b1));
        wait_drained();

        // random part: random keys per phase (all-zero in the last phase), mostly short messages
        n = 0;
        for (int phase = 0; phase < 6; phase++) begin
            tx_no_idle = (phase == 2);
            rx_no_idle = (phase == 2);
            for (int i = 0; i < KeyWords; i++)
                write_key(i, (phase == 5) ? 64'h0 : {$urandom, $urandom});
            cfg_off();
            while (n < 16 * (phase + 1)) begin
                gap_word = $urandom_range(1, (($urandom_range(9) == 0) ? 70 : 12));
                if (gap_word > 16 * (phase + 1) - n)
                    gap_word = 16 * (phase + 1) - n;
                for (int b = 0; b < gap_word; b++) begin
                    r = mk_req(8'($urandom), ($urandom_range(9) != 0), (b == gap_word - 1));
                    send_req(r);
                    n++;
                end
            end
            // sender pause until every MAC word is back
            wait_drained();
        end
        tx_done = 1'b1;

        while (mac_queue.size() != 0)
            @(negedge i_clk);
        repeat (DrainCycles) @(negedge i_clk);
        if (errors == 0)
            $display("[hmac_sha1_engine_core] OK");
        else
            $display("[hmac_sha1_engine_core] ERROR");
        $finish;
    end
endmodule
